FILE: src/assert_macros.svh
// Shared assertion macros for the correlation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition on one edge implies a consequence on the next edge.
`define RC_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> conseq) else $error(msg);

`endif

FILE: src/rc_pkg.sv
package rc_pkg;

  localparam int SampleBits   = 16;
  localparam int MaxWindow    = 256;
  localparam int SlotBits     = 8;
  localparam int CountBits    = 9;
  localparam int SumBits      = 24;
  localparam int SqBits       = 40;
  localparam int TermBits     = 48;
  localparam int AccBits      = 96;
  localparam int FracShift    = 30;
  localparam int WideBits     = AccBits + FracShift;
  localparam int QuotBits     = 31;
  localparam int RootBits     = 32;
  localparam int RootSteps    = 16;
  localparam int CorrBits     = 16;
  localparam int MagBits      = 15;
  localparam int QueueDepth   = 2;
  localparam int QueuePtrBits = 1;

  localparam logic [MagBits-1:0]   OneQ    = 15'd16384;
  localparam logic [RootBits-1:0]  SqrtOne = 32'h4000_0000;
  localparam logic [CountBits-1:0] WindowReset = 9'd16;

  typedef struct packed {
    logic signed [SampleBits-1:0] x_sample;
    logic signed [SampleBits-1:0] y_sample;
    logic                         series_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [CorrBits-1:0] correlation;
    logic                       computed;
    logic                       final_pair;
  } out_beat_t;

  typedef struct packed {
    logic [CountBits-1:0]      pairs;
    logic signed [SumBits-1:0] sum_x;
    logic signed [SumBits-1:0] sum_y;
    logic signed [SqBits-1:0]  sum_xx;
    logic signed [SqBits-1:0]  sum_yy;
    logic signed [SqBits-1:0]  sum_xy;
    logic                      evaluate;
    logic                      last;
  } job_t;

endpackage

FILE: src/rolling_correlation.sv
// Channel | Dir | Handshake               | Beat
// in      | in  | in_valid_i/in_ready_o   | in_beat_t  {x_sample, y_sample, series_end}
// out     | out | out_valid_o/out_ready_i | out_beat_t {correlation, computed, final_pair}
// cfg     | in  | cfg_valid_i/cfg_ready_o | window_len, 9 bits
//
// Front end takes a new pair only once the last is pushed; it feeds a 2-deep
// job queue. A pair that yields a correlation runs 17 products on one 32x32
// multiplier, 31 divide steps and 16 root steps in the back end; a zero variance
// stops it after the variance products with 0. A pair with no correlation goes straight out.
// Reset: window_len = 16, window empty; history memory is not cleared.
// A stalled output holds the back end; the front keeps going until the queue fills.
module rolling_correlation import rc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CountBits-1:0] cfg_data_i
);

  logic [CountBits-1:0] window_len_q;
  logic job_valid, job_ready, deq_valid, deq_ready;
  job_t job, deq_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WindowReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_len_q <= cfg_data_i;
    end
  end

  rc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .window_len_i (window_len_q),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job)
  );

  rc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (deq_valid),
    .pop_ready_i  (deq_ready),
    .pop_data_o   (deq_job)
  );

  rc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (deq_valid),
    .job_ready_o (deq_ready),
    .job_i       (deq_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/rc_front.sv
module rc_front import rc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_beat_t             in_data_i,
  input  logic [CountBits-1:0] window_len_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output job_t                 job_o
);

  typedef enum logic [1:0] {F_IDLE, F_PROD, F_UPD} fstate_e;

  fstate_e state_q;
  logic [SlotBits-1:0]  slot_q;
  logic [CountBits-1:0] pairs_q, pairs_n, w_eff;
  logic signed [SumBits-1:0] sum_x_q, sum_y_q, sum_x_n, sum_y_n;
  logic signed [SqBits-1:0]  sum_xx_q, sum_yy_q, sum_xy_q, sum_xx_n, sum_yy_n, sum_xy_n;
  logic signed [SampleBits-1:0] x_q, y_q, old_x_q, old_y_q;
  logic last_q, drop_q, accept, push;
  logic signed [2*SampleBits-1:0] nxx_q, nyy_q, nxy_q, oxx_q, oyy_q, oxy_q;
  logic [SlotBits-1:0] rd_slot;
  logic signed [SampleBits-1:0] x_mem [MaxWindow];
  logic signed [SampleBits-1:0] y_mem [MaxWindow];

  always_comb begin
    if (window_len_i == '0) begin
      w_eff = CountBits'(1);
    end else if (window_len_i > CountBits'(MaxWindow)) begin
      w_eff = CountBits'(MaxWindow);
    end else begin
      w_eff = window_len_i;
    end
  end

  assign in_ready_o  = (state_q == F_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = (state_q == F_UPD);
  assign push        = job_valid_o && job_ready_i;
  // oldest held pair sits pairs_q slots behind the write slot
  assign rd_slot     = slot_q - pairs_q[SlotBits-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_x_q <= x_mem[rd_slot];
      old_y_q <= y_mem[rd_slot];
    end
    if (push) begin
      x_mem[slot_q] <= x_q;
      y_mem[slot_q] <= y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= in_data_i.x_sample;
      y_q    <= in_data_i.y_sample;
      last_q <= in_data_i.series_end;
      drop_q <= (pairs_q >= w_eff);
    end
    if (state_q == F_PROD) begin
      nxx_q <= x_q * x_q;
      nyy_q <= y_q * y_q;
      nxy_q <= x_q * y_q;
      oxx_q <= drop_q ? old_x_q * old_x_q : (2*SampleBits)'(0);
      oyy_q <= drop_q ? old_y_q * old_y_q : (2*SampleBits)'(0);
      oxy_q <= drop_q ? old_x_q * old_y_q : (2*SampleBits)'(0);
    end
  end

  always_comb begin
    pairs_n  = drop_q ? pairs_q : pairs_q + CountBits'(1);
    sum_x_n  = sum_x_q + SumBits'(x_q) - (drop_q ? SumBits'(old_x_q) : SumBits'(0));
    sum_y_n  = sum_y_q + SumBits'(y_q) - (drop_q ? SumBits'(old_y_q) : SumBits'(0));
    sum_xx_n = sum_xx_q + SqBits'(nxx_q) - SqBits'(oxx_q);
    sum_yy_n = sum_yy_q + SqBits'(nyy_q) - SqBits'(oyy_q);
    sum_xy_n = sum_xy_q + SqBits'(nxy_q) - SqBits'(oxy_q);
    job_o.pairs    = pairs_n;
    job_o.sum_x    = sum_x_n;
    job_o.sum_y    = sum_y_n;
    job_o.sum_xx   = sum_xx_n;
    job_o.sum_yy   = sum_yy_n;
    job_o.sum_xy   = sum_xy_n;
    job_o.evaluate = (pairs_n >= w_eff) || last_q;
    job_o.last     = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      slot_q   <= '0;
      pairs_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) state_q <= F_PROD;
        end
        F_PROD: begin
          state_q <= F_UPD;
        end
        F_UPD: begin
          if (job_ready_i) begin
            state_q <= F_IDLE;
            if (last_q) begin
              slot_q   <= '0;
              pairs_q  <= '0;
              sum_x_q  <= '0;
              sum_y_q  <= '0;
              sum_xx_q <= '0;
              sum_yy_q <= '0;
              sum_xy_q <= '0;
            end else begin
              slot_q   <= slot_q + SlotBits'(1);
              pairs_q  <= pairs_n;
              sum_x_q  <= sum_x_n;
              sum_y_q  <= sum_y_n;
              sum_xx_q <= sum_xx_n;
              sum_yy_q <= sum_yy_n;
              sum_xy_q <= sum_xy_n;
            end
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: src/rc_queue.sv
`include "assert_macros.svh"
module rc_queue import rc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  localparam int CntBits = $clog2(QueueDepth + 1);

  job_t entry_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic push, pop;

  assign push_ready_o = (count_q != CntBits'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QueuePtrBits'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QueuePtrBits'(1);
      if (push && !pop) begin
        count_q <= count_q + CntBits'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  `RC_ASSERT(a_full_ptrs, clk_i, rst_ni, (count_q == CntBits'(QueueDepth)) |-> (wr_ptr_q == rd_ptr_q), "queue full but pointers differ")
  `RC_ASSERT_NEXT(a_count_step, clk_i, rst_ni, (push && !pop), (count_q != '0), "push lost in queue")

endmodule

FILE: src/rc_root.sv
`include "assert_macros.svh"
module rc_root import rc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AccBits-1:0] num_i,
  input  logic [AccBits-1:0] den_i,
  output logic               done_o,
  output logic [MagBits-1:0] root_o
);

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_e;

  rstate_e state_q;
  logic [WideBits-1:0] rem_q, dvs_q;
  logic [QuotBits-1:0] quot_q, quot_d;
  logic [4:0] cnt_q;
  logic [RootBits-1:0] sq_rem_q, sq_res_q, sq_one_q, trial, sq_res_d, rnd;
  logic [MagBits-1:0] root_q;
  logic done_q, fits;

  assign fits  = (rem_q >= dvs_q);
  assign quot_d = {quot_q[QuotBits-2:0], fits};
  assign trial = sq_res_q + sq_one_q;
  assign sq_res_d = (sq_rem_q >= trial) ? (sq_res_q >> 1) + sq_one_q : (sq_res_q >> 1);
  // round(sqrt) taken as the largest m with (2m-1)^2 <= quotient
  assign rnd    = (sq_res_d + RootBits'(1)) >> 1;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          rem_q  <= {num_i, FracShift'(0)};
          dvs_q  <= {den_i, FracShift'(0)};
          quot_q <= '0;
        end
      end
      R_DIV: begin
        if (fits) rem_q <= rem_q - dvs_q;
        dvs_q  <= dvs_q >> 1;
        quot_q <= quot_d;
        if (cnt_q == 5'(QuotBits - 1)) begin
          sq_rem_q <= RootBits'(quot_d);
          sq_res_q <= '0;
          sq_one_q <= SqrtOne;
        end
      end
      R_SQRT: begin
        if (sq_rem_q >= trial) sq_rem_q <= sq_rem_q - trial;
        sq_res_q <= sq_res_d;
        sq_one_q <= sq_one_q >> 2;
        root_q   <= (rnd > RootBits'(OneQ)) ? OneQ : rnd[MagBits-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        R_IDLE: begin
          if (start_i) begin
            state_q <= R_DIV;
            cnt_q   <= '0;
          end
        end
        R_DIV: begin
          if (cnt_q == 5'(QuotBits - 1)) begin
            state_q <= R_SQRT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        R_SQRT: begin
          if (cnt_q == 5'(RootSteps - 1)) begin
            state_q <= R_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  // |cov|^2 <= vx*vy, so the quotient never passes 2^30
  `RC_ASSERT(a_quot_bound, clk_i, rst_ni, (state_q == R_SQRT && cnt_q == '0) |-> (sq_rem_q <= SqrtOne), "quotient above one")

endmodule

FILE: src/rc_back.sv
`include "assert_macros.svh"
module rc_back import rc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_ACC, B_ROOT, B_OUT} bstate_e;

  localparam logic [4:0] StepCovEnd = 5'd2;
  localparam logic [4:0] StepVxEnd  = 5'd5;
  localparam logic [4:0] StepVyEnd  = 5'd8;
  localparam logic [4:0] StepDenEnd = 5'd12;
  localparam logic [4:0] StepNumEnd = 5'd16;

  bstate_e state_q;
  job_t job_q;
  logic [4:0] step_q;
  logic [63:0] prod_q;
  logic [AccBits-1:0] acc_q, acc_n, term, den_q, acc_abs;
  logic [TermBits-1:0] cov_mag_q, vx_q, vy_q;
  logic cov_neg_q, vx_ok_q, root_start, root_done, out_valid_q;
  logic signed [CorrBits-1:0] res_q;
  logic [MagBits-1:0] root_mag;
  out_beat_t out_q;
  logic [31:0] op_a, op_b;
  logic [1:0] op_sh;
  logic op_neg;
  logic [SqBits-1:0] mxy, mxx, myy;
  logic [SumBits-1:0] mx, my;
  logic sxy_neg, sx_neg, sy_neg;

  assign sxy_neg = job_q.sum_xy[SqBits-1];
  assign sx_neg  = job_q.sum_x[SumBits-1];
  assign sy_neg  = job_q.sum_y[SumBits-1];
  assign mxy = sxy_neg ? SqBits'(-job_q.sum_xy) : SqBits'(job_q.sum_xy);
  assign mxx = SqBits'(job_q.sum_xx);
  assign myy = SqBits'(job_q.sum_yy);
  assign mx  = sx_neg ? SumBits'(-job_q.sum_x) : SumBits'(job_q.sum_x);
  assign my  = sy_neg ? SumBits'(-job_q.sum_y) : SumBits'(job_q.sum_y);

  // one 32x32 product per step: three diff terms, then vx*vy and cov^2
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sh  = 2'd0;
    op_neg = 1'b0;
    unique case (step_q)
      5'd0:  begin op_a = 32'(job_q.pairs); op_b = mxy[31:0]; op_neg = sxy_neg; end
      5'd1:  begin
        op_a = 32'(job_q.pairs); op_b = 32'(mxy[SqBits-1:32]); op_sh = 2'd1; op_neg = sxy_neg;
      end
      5'd2:  begin op_a = 32'(mx); op_b = 32'(my); op_neg = !(sx_neg ^ sy_neg); end
      5'd3:  begin op_a = 32'(job_q.pairs); op_b = mxx[31:0]; end
      5'd4:  begin op_a = 32'(job_q.pairs); op_b = 32'(mxx[SqBits-1:32]); op_sh = 2'd1; end
      5'd5:  begin op_a = 32'(mx); op_b = 32'(mx); op_neg = 1'b1; end
      5'd6:  begin op_a = 32'(job_q.pairs); op_b = myy[31:0]; end
      5'd7:  begin op_a = 32'(job_q.pairs); op_b = 32'(myy[SqBits-1:32]); op_sh = 2'd1; end
      5'd8:  begin op_a = 32'(my); op_b = 32'(my); op_neg = 1'b1; end
      5'd9:  begin op_a = vx_q[31:0]; op_b = vy_q[31:0]; end
      5'd10: begin op_a = vx_q[31:0]; op_b = 32'(vy_q[TermBits-1:32]); op_sh = 2'd1; end
      5'd11: begin op_a = 32'(vx_q[TermBits-1:32]); op_b = vy_q[31:0]; op_sh = 2'd1; end
      5'd12: begin
        op_a = 32'(vx_q[TermBits-1:32]); op_b = 32'(vy_q[TermBits-1:32]); op_sh = 2'd2;
      end
      5'd13: begin op_a = cov_mag_q[31:0]; op_b = cov_mag_q[31:0]; end
      5'd14: begin
        op_a = cov_mag_q[31:0]; op_b = 32'(cov_mag_q[TermBits-1:32]); op_sh = 2'd1;
      end
      5'd15: begin
        op_a = 32'(cov_mag_q[TermBits-1:32]); op_b = cov_mag_q[31:0]; op_sh = 2'd1;
      end
      5'd16: begin
        op_a = 32'(cov_mag_q[TermBits-1:32]); op_b = 32'(cov_mag_q[TermBits-1:32]);
        op_sh = 2'd2;
      end
      default: ;
    endcase
  end

  assign term    = AccBits'(prod_q) << {op_sh, 5'b0};
  assign acc_n   = op_neg ? acc_q - term : acc_q + term;
  assign acc_abs = acc_n[AccBits-1] ? -acc_n : acc_n;
  assign root_start = (state_q == B_ACC) && (step_q == StepNumEnd);

  rc_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .num_i   (acc_n),
    .den_i   (den_q),
    .done_o  (root_done),
    .root_o  (root_mag)
  );

  assign job_ready_o = (state_q == B_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && job_valid_i) begin
      job_q <= job_i;
      acc_q <= '0;
      res_q <= '0;
    end
    if (state_q == B_MUL) prod_q <= op_a * op_b;
    if (state_q == B_ACC) begin
      acc_q <= acc_n;
      unique case (step_q)
        StepCovEnd: begin
          cov_neg_q <= acc_n[AccBits-1];
          cov_mag_q <= acc_abs[TermBits-1:0];
          acc_q     <= '0;
        end
        StepVxEnd: begin
          vx_q    <= acc_n[TermBits-1:0];
          vx_ok_q <= !acc_n[AccBits-1] && (acc_n != '0);
          acc_q   <= '0;
        end
        StepVyEnd: begin
          vy_q  <= acc_n[TermBits-1:0];
          acc_q <= '0;
        end
        StepDenEnd: begin
          den_q <= acc_n;
          acc_q <= '0;
        end
        default: ;
      endcase
    end
    if (state_q == B_ROOT && root_done) begin
      res_q <= cov_neg_q ? -CorrBits'(root_mag) : CorrBits'(root_mag);
    end
    if (state_q == B_OUT && (!out_valid_q || out_ready_i)) begin
      out_q.correlation <= res_q;
      out_q.computed    <= job_q.evaluate;
      out_q.final_pair  <= job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            step_q  <= '0;
            state_q <= job_i.evaluate ? B_MUL : B_OUT;
          end
        end
        B_MUL: state_q <= B_ACC;
        B_ACC: begin
          if (step_q == StepVyEnd &&
              (!vx_ok_q || acc_n[AccBits-1] || acc_n == '0)) begin
            state_q <= B_OUT;   // a zero variance gives 0
          end else if (step_q == StepNumEnd) begin
            state_q <= B_ROOT;
          end else begin
            step_q  <= step_q + 5'd1;
            state_q <= B_MUL;
          end
        end
        B_ROOT: begin
          if (root_done) state_q <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `RC_ASSERT(a_corr_range, clk_i, rst_ni, out_valid_q |-> (out_q.correlation <= 16'sd16384 && out_q.correlation >= -16'sd16384), "correlation out of range")
  `RC_ASSERT(a_idle_zero, clk_i, rst_ni, (out_valid_q && !out_q.computed) |-> (out_q.correlation == '0), "nonzero result without evaluation")

endmodule

FILE: test/rolling_correlation_tb.sv
module rolling_correlation_tb;
  import rc_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int HoldCycles = 600;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_beat_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_beat_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CountBits-1:0] cfg_data_i;

  rolling_correlation u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state
  logic [CountBits-1:0] win_len;
  shortint              hist_x [MaxWindow];
  shortint              hist_y [MaxWindow];
  int                   slot;
  int                   held;
  longint               acc_x, acc_y, acc_xx, acc_yy, acc_xy;

  in_beat_t  pending_pairs [$];
  out_beat_t expected_corr [$];

  int  n_pairs, n_results, n_computed, n_saturated, n_cfg, errors;
  int  cycle_cnt, idle_cnt, hold_cnt;
  bit  hold_done, in_taken;

  function automatic logic signed [127:0] moment_term(longint n, longint s2, longint s0,
                                                      longint s1);
    logic signed [127:0] p, q;
    p = n;
    p = p * s2;
    q = s0;
    q = q * s1;
    return p - q;
  endfunction

  function automatic int pearson_q14(longint n);
    logic signed [127:0] cov, vx, vy;
    logic [159:0]        den, num, cm, lhs;
    int                  lo, hi, mid;
    longint              k;
    cov = moment_term(n, acc_xy, acc_x, acc_y);
    vx  = moment_term(n, acc_xx, acc_x, acc_x);
    vy  = moment_term(n, acc_yy, acc_y, acc_y);
    if (vx <= 0 || vy <= 0) return 0;
    den = 160'(vx) * 160'(vy);
    cm  = (cov < 0) ? 160'(-cov) : 160'(cov);
    num = (cm * cm) << FracShift;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k   = 2 * mid - 1;
      lhs = 160'(k * k) * den;
      if (lhs <= num) lo = mid;
      else hi = mid - 1;
    end
    return (cov < 0) ? -lo : lo;
  endfunction

  function automatic out_beat_t predict_corr(in_beat_t b);
    out_beat_t r;
    int        w, s;
    longint    ox, oy, x, y;
    w = win_len;
    if (w < 1) w = 1;
    if (w > MaxWindow) w = MaxWindow;
    x = b.x_sample;
    y = b.y_sample;
    if (held >= w) begin
      s = (slot + MaxWindow - held) % MaxWindow;
      ox = hist_x[s];
      oy = hist_y[s];
      acc_x -= ox; acc_y -= oy;
      acc_xx -= ox * ox; acc_yy -= oy * oy; acc_xy -= ox * oy;
    end else begin
      held++;
    end
    acc_x += x; acc_y += y;
    acc_xx += x * x; acc_yy += y * y; acc_xy += x * y;
    hist_x[slot] = b.x_sample;
    hist_y[slot] = b.y_sample;
    slot = (slot + 1) % MaxWindow;
    r.correlation = '0;
    r.computed    = 1'b0;
    r.final_pair  = b.series_end;
    if (held >= w || b.series_end) begin
      r.correlation = 16'(pearson_q14(held));
      r.computed    = 1'b1;
    end
    if (b.series_end) begin
      slot = 0; held = 0;
      acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
    end
    return r;
  endfunction

  function automatic bit quiet_stretch();
    return cycle_cnt >= 3000 && cycle_cnt < 9000;
  endfunction

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_pairs.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 6)) begin
        in_data_i  <= pending_pairs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && n_pairs >= 200) begin
      hold_done = 1'b1;
      hold_cnt  = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet_stretch() || $urandom_range(99) >= 6;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    out_beat_t exp_b;
    bit        fired;
    cycle_cnt++;
    in_taken <= in_valid_i && in_ready_o;
    fired = (cfg_valid_i && cfg_ready_o);
    if (rst_ni && in_valid_i && in_ready_o) begin
      fired = 1'b1;
      n_pairs++;
      expected_corr.push_back(predict_corr(in_data_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      fired = 1'b1;
      n_results++;
      if (expected_corr.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_b = expected_corr.pop_front();
        if (out_data_o.correlation !== exp_b.correlation) begin
          $error("correlation: expected %0d, got %0d", exp_b.correlation,
                 out_data_o.correlation);
          errors++;
        end
        if (out_data_o.computed !== exp_b.computed) begin
          $error("computed: expected %0b, got %0b", exp_b.computed, out_data_o.computed);
          errors++;
        end
        if (out_data_o.final_pair !== exp_b.final_pair) begin
          $error("final_pair: expected %0b, got %0b", exp_b.final_pair,
                 out_data_o.final_pair);
          errors++;
        end
        if (exp_b.computed) n_computed++;
        if (exp_b.correlation == 16384 || exp_b.correlation == -16384) n_saturated++;
      end
    end
    idle_cnt = fired ? 0 : idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("Timeout: no beat for %0d cycles", IdleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_window(int v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[CountBits-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    win_len = v[CountBits-1:0];
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_valid_i || expected_corr.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic void push_pair(int x, int y, bit last);
    in_beat_t b;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    b.x_sample   = 16'(x);
    b.y_sample   = 16'(y);
    b.series_end = last;
    pending_pairs.push_back(b);
  endfunction

  // mode: 0 random full scale, 1 correlated, 2 anticorrelated, 3 small, 4 flat x
  function automatic void push_series(int len, int mode, bit close);
    int x, y, fx;
    fx = $urandom_range(65535) - 32768;
    for (int i = 0; i < len; i++) begin
      x = $urandom_range(65535) - 32768;
      case (mode)
        1: y = x + $urandom_range(2000) - 1000;
        2: y = -x + $urandom_range(2000) - 1000;
        3: begin
          x = $urandom_range(6) - 3;
          y = $urandom_range(6) - 3;
        end
        4: begin
          x = fx;
          y = $urandom_range(65535) - 32768;
        end
        default: y = $urandom_range(65535) - 32768;
      endcase
      push_pair(x, y, close && i == len - 1);
    end
  endfunction

  initial begin
    int w, len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_taken = 1'b0;
    win_len = WindowReset;
    slot = 0; held = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset window length, then lengths 1 and 0
    push_pair(1234, -77, 1'b1);
    push_pair(-32768, 32767, 1'b0);
    push_pair(32767, -32768, 1'b1);
    push_pair(32767, 32767, 1'b0);
    push_pair(-32768, -32768, 1'b1);
    push_series(18, 4, 1'b1);
    wait_drained();
    write_window(1);
    push_pair(-1, 1, 1'b0);
    push_pair(0, 0, 1'b1);
    wait_drained();
    write_window(0);
    push_series(3, 0, 1'b1);
    wait_drained();

    // random phases; some series run across a length change
    while (n_pairs + pending_pairs.size() < 850) begin
      case ($urandom_range(9))
        0: w = 256;
        1: w = 511;
        2: w = $urandom_range(511);
        default: w = $urandom_range(24, 1);
      endcase
      write_window(w);
      for (int s = 0; s < 4; s++) begin
        len = (w > 40 && s == 0) ? $urandom_range(300, 200) : $urandom_range(40, 1);
        if (w > 40 && $urandom_range(1)) len = $urandom_range(30, 1);
        push_series(len, $urandom_range(4), s < 3 || $urandom_range(1));
      end
      wait_drained();
    end
    write_window(256);
    push_series(2, 1, 1'b1);
    wait_drained();

    $display("Checked %0d pairs over %0d window settings: %0d correlations, %0d at +-1",
             n_pairs, n_cfg, n_computed, n_saturated);
    if (errors == 0 && expected_corr.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/rc_pkg.sv
src/rc_front.sv
src/rc_queue.sv
src/rc_root.sv
src/rc_back.sv
src/rolling_correlation.sv
test/rolling_correlation_tb.sv
